>>> rtl/rc4kg_pkg.sv
// RC4 keystream generator: shared types and constants.
// Used by rc4kg_ctrl, rc4kg_datapath and rc4_keystream_generator.
package rc4kg_pkg;

  localparam int PERM_DEPTH = 256;
  localparam int ADDR_W     = 2;
  localparam logic [ADDR_W-1:0] ADDR_SEED_KEY = 2'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_RD_N,
    ST_KS_RD_ACC,
    ST_KS_WR_N,
    ST_KS_WR_ACC,
    ST_G_RD_I,
    ST_G_RD_J,
    ST_G_WR_I,
    ST_G_WR_J,
    ST_G_OUT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_KS_RD_N,
    OP_KS_RD_ACC,
    OP_KS_WR_N,
    OP_KS_WR_ACC,
    OP_G_RD_I,
    OP_G_RD_J,
    OP_G_WR_I,
    OP_G_WR_J,
    OP_G_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   take_in;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic n_last;
  } dp_sts_t;

endpackage

>>> rtl/rc4_keystream_generator.sv
// RC4 keystream generator top level: APB key register decode and block wiring.
// Depends on rc4kg_pkg, rc4kg_ctrl and rc4kg_datapath.
//
// channel  | handshake             | payload
// req      | req_valid/req_ready   | last_of_request
// key      | key_valid/key_ready   | key_byte, last_byte
// apb      | psel/penable/pready   | pwrite, paddr, pwdata, prdata
//
// A byte runs through an idle step, four memory steps on the permutation
// (read S[i], read S[j], two swap writes on the single write port) and one output read.
// The first request after reset or a key write first runs the key schedule: a fill
// of all 256 entries, then for each entry two reads and two writes for the mixing swap.
// Reset is synchronous; i, j, the key and the schedule flag clear, the memory does not.
// A result waits in the output register; the next item is taken meanwhile, and
// the block stalls at its output step only while that register is still full.
module rc4_keystream_generator
  import rc4kg_pkg::*;
#(
  parameter int KEY_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              last_of_request,
  output logic              key_valid,
  input  logic              key_ready,
  output logic [7:0]        key_byte,
  output logic              last_byte,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic        cfg_wr;
  logic [31:0] seed_key;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_SEED_KEY);
  assign prdata = (paddr == ADDR_SEED_KEY) ? seed_key : 32'd0;

  rc4kg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .key_valid (key_valid),
    .key_ready (key_ready),
    .cfg_wr    (cfg_wr),
    .cmd       (cmd),
    .sts       (sts)
  );

  rc4kg_datapath #(
    .KEY_BYTES (KEY_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .last_of_request (last_of_request),
    .cfg_wr          (cfg_wr),
    .cfg_wdata       (pwdata),
    .seed_key        (seed_key),
    .key_byte        (key_byte),
    .last_byte       (last_byte)
  );

endmodule

>>> rtl/rc4kg_ctrl.sv
// RC4 keystream generator controller: sequencing of key schedule and byte steps.
// Depends on rc4kg_pkg; drives rc4kg_datapath through dp_cmd_t.
module rc4kg_ctrl
  import rc4kg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  output logic    key_valid,
  input  logic    key_ready,
  input  logic    cfg_wr,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  ctrl_state_t state, state_next;
  logic        scheduled;
  logic        out_free;

  assign out_free  = !key_valid || key_ready;
  assign req_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scheduled <= 1'b0;
    end else if (cfg_wr) begin
      scheduled <= 1'b0;
    end else if (state == ST_KS_WR_ACC && sts.n_last) begin
      scheduled <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (cmd.load_out) begin
      key_valid <= 1'b1;
    end else if (key_ready) begin
      key_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.take_in  = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.take_in = 1'b1;
          state_next  = scheduled ? ST_G_RD_I : ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.op = OP_INIT;
        if (sts.n_last) begin
          state_next = ST_KS_RD_N;
        end
      end
      ST_KS_RD_N: begin
        cmd.op     = OP_KS_RD_N;
        state_next = ST_KS_RD_ACC;
      end
      ST_KS_RD_ACC: begin
        cmd.op     = OP_KS_RD_ACC;
        state_next = ST_KS_WR_N;
      end
      ST_KS_WR_N: begin
        cmd.op     = OP_KS_WR_N;
        state_next = ST_KS_WR_ACC;
      end
      ST_KS_WR_ACC: begin
        cmd.op     = OP_KS_WR_ACC;
        state_next = sts.n_last ? ST_G_RD_I : ST_KS_RD_N;
      end
      ST_G_RD_I: begin
        cmd.op     = OP_G_RD_I;
        state_next = ST_G_RD_J;
      end
      ST_G_RD_J: begin
        cmd.op     = OP_G_RD_J;
        state_next = ST_G_WR_I;
      end
      ST_G_WR_I: begin
        cmd.op     = OP_G_WR_I;
        state_next = ST_G_WR_J;
      end
      ST_G_WR_J: begin
        cmd.op     = OP_G_WR_J;
        state_next = ST_G_OUT;
      end
      ST_G_OUT: begin
        cmd.op = OP_G_OUT;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_sched_skip: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && scheduled) |=> (state == ST_G_RD_I))
    else $error("scheduled request did not go straight to byte generation");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!key_valid || key_ready))
    else $error("result loaded over an untaken item");

  a_cfg_resched: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> !scheduled)
    else $error("key write did not force a new schedule");

  a_out_leave: assert property (@(posedge clk) disable iff (rst)
    (state == ST_G_OUT && out_free) |=> (state == ST_IDLE && key_valid))
    else $error("result step did not deliver the item");
`endif

endmodule

>>> rtl/rc4kg_datapath.sv
// RC4 keystream generator datapath: permutation memory, indices, key register.
// Depends on rc4kg_pkg; commanded by rc4kg_ctrl.
module rc4kg_datapath
  import rc4kg_pkg::*;
#(
  parameter int KEY_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic        last_of_request,
  input  logic        cfg_wr,
  input  logic [31:0] cfg_wdata,
  output logic [31:0] seed_key,
  output logic [7:0]  key_byte,
  output logic        last_byte
);

  localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  logic [7:0]    mem [PERM_DEPTH];
  logic [7:0]    n;
  logic [KW-1:0] kidx;
  logic [7:0]    acc;
  logic [7:0]    idx_i;
  logic [7:0]    idx_j;
  logic [7:0]    si;
  logic [7:0]    sj;
  logic          last_q;
  logic [7:0]    rd_a;
  logic [7:0]    rd_b;
  logic [7:0]    addr_a;
  logic [7:0]    addr_b;
  logic          we;
  logic [7:0]    wa;
  logic [7:0]    wd;
  logic [63:0]   key_ext;
  logic [7:0]    kbyte;
  logic [7:0]    sum;
  logic [7:0]    result;

  assign key_ext    = {32'd0, seed_key};
  assign kbyte      = key_ext[{kidx, 3'b000} +: 8];
  assign sum        = si + sj;
  assign result     = (sum == idx_j) ? si : rd_a;
  assign sts.n_last = (n == 8'hFF);

  always_comb begin
    addr_a = n;
    addr_b = acc;
    we     = 1'b0;
    wa     = n;
    wd     = n;
    unique case (cmd.op)
      OP_INIT: begin
        we = 1'b1;
      end
      OP_KS_RD_ACC: begin
        addr_b = acc + rd_a + kbyte;
      end
      OP_KS_WR_N: begin
        we = 1'b1;
        wd = rd_b;
      end
      OP_KS_WR_ACC: begin
        we = 1'b1;
        wa = acc;
        wd = si;
      end
      OP_G_RD_I: begin
        addr_a = idx_i + 8'd1;
      end
      OP_G_RD_J: begin
        addr_b = idx_j + rd_a;
      end
      OP_G_WR_I: begin
        we = 1'b1;
        wa = idx_i;
        wd = rd_b;
      end
      OP_G_WR_J: begin
        we     = 1'b1;
        wa     = idx_j;
        wd     = si;
        addr_a = sum;
      end
      OP_G_OUT: begin
        addr_a = sum;
      end
      OP_NONE, OP_KS_RD_N: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_a <= mem[addr_a];
  end

  always_ff @(posedge clk) begin
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_key <= 32'd0;
    end else if (cfg_wr) begin
      seed_key <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n     <= 8'd0;
      idx_i <= 8'd0;
      idx_j <= 8'd0;
    end else begin
      if (cmd.op == OP_INIT || cmd.op == OP_KS_WR_ACC) begin
        n <= n + 8'd1;
      end
      if (cmd.op == OP_KS_WR_ACC && sts.n_last) begin
        idx_i <= 8'd0;
        idx_j <= 8'd0;
      end else if (cmd.op == OP_G_RD_I) begin
        idx_i <= addr_a;
      end else if (cmd.op == OP_G_RD_J) begin
        idx_j <= addr_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_INIT) begin
      acc  <= 8'd0;
      kidx <= '0;
    end else if (cmd.op == OP_KS_RD_ACC) begin
      acc <= addr_b;
    end else if (cmd.op == OP_KS_WR_ACC) begin
      kidx <= (kidx == KW'(KEY_BYTES - 1)) ? '0 : kidx + KW'(1);
    end
    if (cmd.op == OP_KS_RD_ACC || cmd.op == OP_G_RD_J) begin
      si <= rd_a;
    end
    if (cmd.op == OP_G_WR_I) begin
      sj <= rd_b;
    end
    if (cmd.take_in) begin
      last_q <= last_of_request;
    end
    if (cmd.load_out) begin
      key_byte  <= result;
      last_byte <= last_q;
    end
  end

endmodule

>>> tb/rc4_keystream_generator_tb.sv
// Testbench for rc4_keystream_generator: checks every keystream byte against a
// built-in RC4 predictor across APB key writes and random idle/stall phases.
// Depends on rc4kg_pkg and the rc4_keystream_generator RTL.
`timescale 1ns / 100ps

module rc4_keystream_generator_tb;
  import rc4kg_pkg::*;

  localparam int KEY_LEN = 4;
  localparam int ERR_PRINT_MAX = 100;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       last_byte;
  } ks_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  logic              last_of_request = 1'b0;
  logic              key_valid;
  logic              key_ready = 1'b0;
  logic [7:0]        key_byte;
  logic              last_byte;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // predictor state
  logic [7:0]  perm [PERM_DEPTH];
  logic [7:0]  idx_i = '0;
  logic [7:0]  idx_j = '0;
  logic        sched_done = 1'b0;
  logic [31:0] seed_reg = '0;

  ks_item_t keystream_q[$];
  logic     req_q[$];
  int       pushed_cnt = 0;
  int       accepted_cnt = 0;
  int       apb_done_cnt = 0;
  int       err_cnt = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  logic     req_fire = 1'b0;

  rc4_keystream_generator #(
    .KEY_BYTES(KEY_LEN)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .last_of_request(last_of_request),
    .key_valid      (key_valid),
    .key_ready      (key_ready),
    .key_byte       (key_byte),
    .last_byte      (last_byte),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] key_at(int k);
    if (k >= 4) return 8'h00;
    return seed_reg[8*k +: 8];
  endfunction

  task automatic rc4_schedule();
    int         n;
    logic [7:0] acc;
    logic [7:0] t;
    acc = '0;
    for (n = 0; n < PERM_DEPTH; n++) perm[n] = n[7:0];
    for (n = 0; n < PERM_DEPTH; n++) begin
      acc = acc + perm[n] + key_at(n % KEY_LEN);
      t = perm[n];
      perm[n] = perm[acc];
      perm[acc] = t;
    end
    idx_i = '0;
    idx_j = '0;
    sched_done = 1'b1;
  endtask

  task automatic rc4_predict(input logic last, output ks_item_t r);
    logic [7:0] t;
    logic [7:0] sum;
    if (!sched_done) rc4_schedule();
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm[idx_i];
    t = perm[idx_i];
    perm[idx_i] = perm[idx_j];
    perm[idx_j] = t;
    sum = perm[idx_i] + perm[idx_j];
    r.key_byte = perm[sum];
    r.last_byte = last;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    if (err_cnt < ERR_PRINT_MAX)
      $display("%0t: %s mismatch: got 0x%0h, exp 0x%0h", $realtime, what, got, exp);
    err_cnt++;
  endtask

  // monitor
  always @(posedge clk) begin
    ks_item_t got;
    ks_item_t exp;
    req_fire <= !rst && req_valid && req_ready;
    if (!rst) begin
      if (key_valid && key_ready) begin
        got.key_byte = key_byte;
        got.last_byte = last_byte;
        if (keystream_q.size() == 0) begin
          report_mismatch("unexpected item", {23'd0, got}, 32'd0);
        end else begin
          exp = keystream_q.pop_front();
          if (got.key_byte !== exp.key_byte)
            report_mismatch("key_byte", {24'd0, got.key_byte}, {24'd0, exp.key_byte});
          if (got.last_byte !== exp.last_byte)
            report_mismatch("last_byte", {31'd0, got.last_byte}, {31'd0, exp.last_byte});
        end
      end
      if (req_valid && req_ready) begin
        rc4_predict(last_of_request, exp);
        keystream_q.push_back(exp);
        accepted_cnt++;
      end
      if (psel && penable && pready) begin
        if (!pwrite && paddr == ADDR_SEED_KEY && prdata !== seed_reg)
          report_mismatch("prdata", prdata, seed_reg);
        if (pwrite && paddr == ADDR_SEED_KEY) begin
          seed_reg = pwdata;
          sched_done = 1'b0;
        end
        apb_done_cnt++;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!req_valid || req_fire) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          last_of_request <= req_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
      key_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [31:0] data);
    int done0;
    done0 = apb_done_cnt;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (apb_done_cnt == done0);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic key_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    apb_access(1'b1, addr, data);
    apb_access(1'b0, ADDR_SEED_KEY, 32'd0);
  endtask

  task automatic push_item(input logic last);
    req_q.push_back(last);
    pushed_cnt++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (accepted_cnt != pushed_cnt || keystream_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int n_items, input int idle, input int stall,
                           input int drain_at);
    int k;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (k = 0; k < n_items; k++) begin
      if (k == drain_at) wait_drained();
      push_item(1'($urandom_range(1)));
    end
    wait_drained();
  endtask

  initial begin
    int k;
    logic [ADDR_W-1:0] bad_addr;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // reset key, no write: schedule on first request
    for (k = 0; k < 6; k++) push_item(k[0]);
    wait_drained();
    key_write(ADDR_SEED_KEY, 32'hFFFF_FFFF);
    for (k = 0; k < 5; k++) push_item(~k[0]);
    wait_drained();
    // writes off the key register leave the stream running
    for (k = 1; k < 4; k++) begin
      bad_addr = k[ADDR_W-1:0];
      apb_access(1'b1, bad_addr, $urandom());
    end
    for (k = 0; k < 4; k++) push_item(k[1]);
    wait_drained();
    key_write(ADDR_SEED_KEY, 32'h0000_0000);
    for (k = 0; k < 4; k++) push_item(k[0]);
    wait_drained();

    key_write(ADDR_SEED_KEY, $urandom());
    run_phase(45, 0, 0, -1);
    key_write(ADDR_SEED_KEY, 32'hFFFF_FFFF);
    apb_access(1'b1, ADDR_W'($urandom_range(3, 1)), $urandom());
    run_phase(45, 66, 0, -1);
    key_write(ADDR_SEED_KEY, $urandom());
    run_phase(45, 0, 66, 30);
    key_write(ADDR_SEED_KEY, $urandom());
    apb_access(1'b1, ADDR_W'($urandom_range(3, 1)), $urandom());
    // long enough for the i index to wrap
    run_phase(300, 24, 24, 150);

    repeat (12) @(negedge clk);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
